FILE: rtl/core/lik_pkg.sv
// Shared constants, tables, types and helpers for the leg inverse kinematics block.
package lik_pkg;

  // field widths
  localparam int POS_W = 16;
  localparam int OFS_W = 14;
  localparam int LEN_W = 14;
  localparam int ANG_W = 16;

  // square root datapath: radicand, root and partial remainder
  localparam int RAD_W  = 62;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  // rotation datapath: operand width, angle accumulator width
  localparam int ROT_W    = 34;
  localparam int ACC_W    = 32;
  localparam int NORM_TOP = 30;
  localparam int NORM_STAGES = 7;

  localparam int ANGLE_ITERATIONS_DEF = 16;
  localparam int ROT_TABLE_LEN = 24;

  localparam logic signed [ACC_W-1:0] PI_Q29 = 32'sd1686629713;

  localparam logic [LEN_W-1:0] THIGH_RST = 14'd3200;
  localparam logic [LEN_W-1:0] CALF_RST  = 14'd3200;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_THIGH = 1'b0,
    REG_CALF  = 1'b1
  } cfg_reg_t;

  // operands that ride along the square root chain
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic signed [OFS_W-1:0] l1;
    logic signed [ROT_W-1:0] n;
    logic                    err;
  } sq_side_t;

  // flags that ride along the rotation chain
  typedef struct packed {
    logic err;
    logic nneg;
  } rot_side_t;

  // atan(2^-i) in Q2.29, rounded to nearest
  function automatic logic signed [ACC_W-1:0] rot_atan(input int i);
    logic signed [ACC_W-1:0] v;
    case (i)
      0:  v = 32'sd421657428;
      1:  v = 32'sd248918915;
      2:  v = 32'sd131521918;
      3:  v = 32'sd66762579;
      4:  v = 32'sd33510843;
      5:  v = 32'sd16771758;
      6:  v = 32'sd8387925;
      7:  v = 32'sd4194219;
      8:  v = 32'sd2097141;
      9:  v = 32'sd1048575;
      10: v = 32'sd524288;
      11: v = 32'sd262144;
      12: v = 32'sd131072;
      13: v = 32'sd65536;
      14: v = 32'sd32768;
      15: v = 32'sd16384;
      16: v = 32'sd8192;
      17: v = 32'sd4096;
      18: v = 32'sd2048;
      19: v = 32'sd1024;
      20: v = 32'sd512;
      21: v = 32'sd256;
      22: v = 32'sd128;
      23: v = 32'sd64;
      default: v = '0;
    endcase
    return v;
  endfunction

  // shift amount of each normalization stage: two right stages, then left
  function automatic int norm_shift(input int k);
    int s;
    case (k)
      0: s = 2;
      1: s = 1;
      2: s = 16;
      3: s = 8;
      4: s = 4;
      5: s = 2;
      default: s = 1;
    endcase
    return s;
  endfunction

  function automatic bit norm_right(input int k);
    return k < 2;
  endfunction

  // Q2.29 to Q3.13, round half up
  function automatic logic [ANG_W-1:0] to_q13(input logic signed [34:0] a);
    logic signed [34:0] t;
    t = a + 35'sd32768;
    return t[31:16];
  endfunction

endpackage

FILE: rtl/core/lik_sqrt_cell.sv
// One restoring square root step per lane: one root bit per cycle while en is high.
module lik_sqrt_cell #(
  parameter int LANES  = 3,
  parameter int SIDE_W = 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   vld_i,
  input  logic [LANES-1:0][lik_pkg::RAD_W-1:0]   rad_i,
  input  logic [LANES-1:0][lik_pkg::REM_W-1:0]   rem_i,
  input  logic [LANES-1:0][lik_pkg::ROOT_W-1:0]  root_i,
  input  logic [SIDE_W-1:0]                      side_i,
  output logic                                   vld_o,
  output logic [LANES-1:0][lik_pkg::RAD_W-1:0]   rad_o,
  output logic [LANES-1:0][lik_pkg::REM_W-1:0]   rem_o,
  output logic [LANES-1:0][lik_pkg::ROOT_W-1:0]  root_o,
  output logic [SIDE_W-1:0]                      side_o
);
  import lik_pkg::*;

  logic [REM_W+1:0]  rem2  [LANES];
  logic [REM_W+1:0]  trial [LANES];
  logic [LANES-1:0][RAD_W-1:0]  rad_next;
  logic [LANES-1:0][REM_W-1:0]  rem_next;
  logic [LANES-1:0][ROOT_W-1:0] root_next;

  // bring down two radicand bits, try to subtract 4*root+1
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem2[l]     = {rem_i[l], rad_i[l][RAD_W-1 -: 2]};
      trial[l]    = {2'b00, root_i[l], 2'b01};
      rad_next[l] = {rad_i[l][RAD_W-3:0], 2'b00};
      if (rem2[l] >= trial[l]) begin
        rem_next[l]  = REM_W'(rem2[l] - trial[l]);
        root_next[l] = {root_i[l][ROOT_W-2:0], 1'b1};
      end else begin
        rem_next[l]  = REM_W'(rem2[l]);
        root_next[l] = {root_i[l][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_o  <= rad_next;
      rem_o  <= rem_next;
      root_o <= root_next;
      side_o <= side_i;
    end
  end

endmodule

FILE: rtl/core/lik_sqrt.sv
// Pipelined integer square root: a chain of one-bit cells over several lanes.
module lik_sqrt #(
  parameter int LANES  = 3,
  parameter int SIDE_W = 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   vld_i,
  input  logic [LANES-1:0][lik_pkg::RAD_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0]                      side_i,
  output logic                                   vld_o,
  output logic [LANES-1:0][lik_pkg::ROOT_W-1:0]  root_o,
  output logic [SIDE_W-1:0]                      side_o
);
  import lik_pkg::*;

  logic                         vc    [ROOT_W+1];
  logic [LANES-1:0][RAD_W-1:0]  radc  [ROOT_W+1];
  logic [LANES-1:0][REM_W-1:0]  remc  [ROOT_W+1];
  logic [LANES-1:0][ROOT_W-1:0] rootc [ROOT_W+1];
  logic [SIDE_W-1:0]            sc    [ROOT_W+1];

  assign vc[0]    = vld_i;
  assign radc[0]  = rad_i;
  assign remc[0]  = '0;
  assign rootc[0] = '0;
  assign sc[0]    = side_i;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    lik_sqrt_cell #(
      .LANES  (LANES),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .vld_i  (vc[k]),
      .rad_i  (radc[k]),
      .rem_i  (remc[k]),
      .root_i (rootc[k]),
      .side_i (sc[k]),
      .vld_o  (vc[k+1]),
      .rad_o  (radc[k+1]),
      .rem_o  (remc[k+1]),
      .root_o (rootc[k+1]),
      .side_o (sc[k+1])
    );
  end

  assign vld_o  = vc[ROOT_W];
  assign root_o = rootc[ROOT_W];
  assign side_o = sc[ROOT_W];

endmodule

FILE: rtl/core/lik_rot_cell.sv
// One vectoring micro-rotation per lane with a fixed shift.
module lik_rot_cell #(
  parameter int IDX    = 0,
  parameter int LANES  = 4,
  parameter int SIDE_W = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  vld_i,
  input  logic [LANES-1:0][lik_pkg::ROT_W-1:0]  x_i,
  input  logic [LANES-1:0][lik_pkg::ROT_W-1:0]  y_i,
  input  logic [LANES-1:0][lik_pkg::ACC_W-1:0]  ang_i,
  input  logic [LANES-1:0]                      zero_i,
  input  logic [SIDE_W-1:0]                     side_i,
  output logic                                  vld_o,
  output logic [LANES-1:0][lik_pkg::ROT_W-1:0]  x_o,
  output logic [LANES-1:0][lik_pkg::ROT_W-1:0]  y_o,
  output logic [LANES-1:0][lik_pkg::ACC_W-1:0]  ang_o,
  output logic [LANES-1:0]                      zero_o,
  output logic [SIDE_W-1:0]                     side_o
);
  import lik_pkg::*;

  localparam logic signed [ACC_W-1:0] STEP = rot_atan(IDX);

  logic signed [ROT_W-1:0] xs [LANES];
  logic signed [ROT_W-1:0] ys [LANES];
  logic signed [ROT_W-1:0] dx [LANES];
  logic signed [ROT_W-1:0] dy [LANES];
  logic [LANES-1:0][ROT_W-1:0] x_next;
  logic [LANES-1:0][ROT_W-1:0] y_next;
  logic [LANES-1:0][ACC_W-1:0] ang_next;

  // rotate toward the x axis, direction by the sign of y
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      xs[l] = $signed(x_i[l]);
      ys[l] = $signed(y_i[l]);
      dx[l] = ys[l] >>> IDX;
      dy[l] = xs[l] >>> IDX;
      if (ys[l] >= 0) begin
        x_next[l]   = xs[l] + dx[l];
        y_next[l]   = ys[l] - dy[l];
        ang_next[l] = $signed(ang_i[l]) + STEP;
      end else begin
        x_next[l]   = xs[l] - dx[l];
        y_next[l]   = ys[l] + dy[l];
        ang_next[l] = $signed(ang_i[l]) - STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_o    <= x_next;
      y_o    <= y_next;
      ang_o  <= ang_next;
      zero_o <= zero_i;
      side_o <= side_i;
    end
  end

endmodule

FILE: rtl/core/lik_rot.sv
// atan2 lanes: magnitude, staged normalization shifts, then a chain of rotation cells.
module lik_rot #(
  parameter int LANES  = 4,
  parameter int SIDE_W = 1,
  parameter int ITER   = lik_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  vld_i,
  input  logic [LANES-1:0][lik_pkg::ROT_W-1:0]  x_i,
  input  logic [LANES-1:0][lik_pkg::ROT_W-1:0]  y_i,
  input  logic [SIDE_W-1:0]                     side_i,
  output logic                                  vld_o,
  output logic [LANES-1:0][lik_pkg::ACC_W-1:0]  ang_o,
  output logic [SIDE_W-1:0]                     side_o
);
  import lik_pkg::*;

  // normalization pipe
  logic                         nv [NORM_STAGES+1];
  logic [LANES-1:0][ROT_W-1:0]  nx [NORM_STAGES+1];
  logic [LANES-1:0][ROT_W-1:0]  ny [NORM_STAGES+1];
  logic [LANES-1:0][ROT_W-1:0]  nm [NORM_STAGES+1];
  logic [LANES-1:0]             nz [NORM_STAGES+1];
  logic [SIDE_W-1:0]            ns [NORM_STAGES+1];

  logic signed [ROT_W-1:0] xi [LANES];
  logic signed [ROT_W-1:0] yi [LANES];
  logic [ROT_W-1:0] ax [LANES];
  logic [ROT_W-1:0] ay [LANES];
  logic [LANES-1:0][ROT_W-1:0] mx;

  // larger magnitude of each operand pair
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      xi[l] = $signed(x_i[l]);
      yi[l] = $signed(y_i[l]);
      ax[l] = (xi[l] < 0) ? ROT_W'(-xi[l]) : ROT_W'(xi[l]);
      ay[l] = (yi[l] < 0) ? ROT_W'(-yi[l]) : ROT_W'(yi[l]);
      mx[l] = (ax[l] > ay[l]) ? ax[l] : ay[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nv[0] <= 1'b0;
    end else if (en) begin
      nv[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx[0] <= x_i;
      ny[0] <= y_i;
      nm[0] <= mx;
      ns[0] <= side_i;
      for (int l = 0; l < LANES; l++) begin
        nz[0][l] <= (mx[l] == '0);
      end
    end
  end

  // shift until the larger magnitude lies in [2^29, 2^30)
  for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
    localparam int SH = norm_shift(k);
    localparam bit RT = norm_right(k);
    localparam logic [ROT_W-1:0] LIM =
      RT ? (ROT_W'(1) << (NORM_TOP - 1 + SH)) : (ROT_W'(1) << (NORM_TOP - SH));

    always_ff @(posedge clk) begin
      if (rst) begin
        nv[k+1] <= 1'b0;
      end else if (en) begin
        nv[k+1] <= nv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nz[k+1] <= nz[k];
        ns[k+1] <= ns[k];
        for (int l = 0; l < LANES; l++) begin
          if (RT && (nm[k][l] >= LIM)) begin
            nx[k+1][l] <= ROT_W'($signed(nx[k][l]) >>> SH);
            ny[k+1][l] <= ROT_W'($signed(ny[k][l]) >>> SH);
            nm[k+1][l] <= nm[k][l] >> SH;
          end else if (!RT && (nm[k][l] < LIM)) begin
            nx[k+1][l] <= nx[k][l] << SH;
            ny[k+1][l] <= ny[k][l] << SH;
            nm[k+1][l] <= nm[k][l] << SH;
          end else begin
            nx[k+1][l] <= nx[k][l];
            ny[k+1][l] <= ny[k][l];
            nm[k+1][l] <= nm[k][l];
          end
        end
      end
    end
  end

  // rotation chain
  logic                         cv [ITER+1];
  logic [LANES-1:0][ROT_W-1:0]  cx [ITER+1];
  logic [LANES-1:0][ROT_W-1:0]  cy [ITER+1];
  logic [LANES-1:0][ACC_W-1:0]  ca [ITER+1];
  logic [LANES-1:0]             cz [ITER+1];
  logic [SIDE_W-1:0]            cs [ITER+1];

  assign cv[0] = nv[NORM_STAGES];
  assign cx[0] = nx[NORM_STAGES];
  assign cy[0] = ny[NORM_STAGES];
  assign ca[0] = '0;
  assign cz[0] = nz[NORM_STAGES];
  assign cs[0] = ns[NORM_STAGES];

  for (genvar i = 0; i < ITER; i++) begin : g_cell
    lik_rot_cell #(
      .IDX    (i),
      .LANES  (LANES),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .vld_i  (cv[i]),
      .x_i    (cx[i]),
      .y_i    (cy[i]),
      .ang_i  (ca[i]),
      .zero_i (cz[i]),
      .side_i (cs[i]),
      .vld_o  (cv[i+1]),
      .x_o    (cx[i+1]),
      .y_o    (cy[i+1]),
      .ang_o  (ca[i+1]),
      .zero_o (cz[i+1]),
      .side_o (cs[i+1])
    );
  end

  // a zero vector has angle zero
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ang_o[l] = cz[ITER][l] ? '0 : ca[ITER][l];
    end
  end

  assign vld_o  = cv[ITER];
  assign side_o = cs[ITER];

endmodule

FILE: rtl/core/leg_inverse_kinematics_3dof.sv
// Top level: three-joint leg inverse kinematics, one target per cycle while the output is not stalled.
//
// Input stream s_axis: one word per foot target (x, y, z, shoulder offset).
// Output stream m_axis: one word per target with abduction, hip pitch and
// knee angles in Q3.13 radians; tuser carries the reach error flag, set when
// the target is out of reach or a divisor is zero.
// Config port: cfg_we writes cfg_wdata to thigh length (index 0) or calf
// length (index 1), in 1/16 mm. Write only while the pipe is empty.
//
// Throughput: one word per cycle while the output is not stalled. Stages:
// eight setup stages with the squares and products, 31 root cells, one
// operand stage, one magnitude and seven normalize stages, one cell per
// rotation step, one output register.
// The whole pipe advances together; when m_axis_tready is low with a word
// waiting, every stage holds and s_axis_tready drops in the same cycle.
// Reset clears all valid bits and loads both lengths with 3200.
module leg_inverse_kinematics_3dof #(
  parameter int ANGLE_ITERATIONS = lik_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [63:0]               s_axis_tdata,  // foot_x, foot_y, foot_z, shoulder_offset
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [47:0]               m_axis_tdata,  // abduction, hip_pitch, knee
  output logic [0:0]                m_axis_tuser,  // reach_error
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_addr,
  input  logic [lik_pkg::LEN_W-1:0] cfg_wdata
);
  import lik_pkg::*;

  localparam int NSTG = 8;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic signed [OFS_W-1:0] l1;
  } pos_t;

  logic [LEN_W-1:0] thigh;
  logic [LEN_W-1:0] calf;
  logic en;
  logic out_vld;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thigh <= THIGH_RST;
      calf  <= CALF_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_THIGH: thigh <= cfg_wdata;
        REG_CALF:  calf  <= cfg_wdata;
      endcase
    end
  end

  assign en = !out_vld || m_axis_tready;
  assign s_axis_tready = en;

  // input unpack and squares
  pos_t in_pos;
  logic signed [31:0] xsq, ysq, zsq;
  logic signed [27:0] l1sq;
  logic [27:0] l2sq, l3sq, l23;

  assign in_pos.x  = s_axis_tdata[15:0];
  assign in_pos.y  = s_axis_tdata[31:16];
  assign in_pos.z  = s_axis_tdata[47:32];
  assign in_pos.l1 = s_axis_tdata[61:48];
  assign xsq  = in_pos.x * in_pos.x;
  assign ysq  = in_pos.y * in_pos.y;
  assign zsq  = in_pos.z * in_pos.z;
  assign l1sq = in_pos.l1 * in_pos.l1;
  assign l2sq = thigh * thigh;
  assign l3sq = calf * calf;
  assign l23  = thigh * calf;

  logic       vld [1:NSTG];
  pos_t       pos [1:NSTG];
  logic       err [2:NSTG];
  logic [30:0] xx1, yy1, zz1, xx2;
  logic [26:0] ll1;
  logic [27:0] l2sq1, l3sq1, l23_1, l2sq2, l3sq2, l23_2, l2sq3, l3sq3, l23_3;
  logic [27:0] l2sq4, l2sq5;
  logic        eq1;
  logic signed [32:0] q2;
  logic [31:0] q3, q4, q5, q6, q7, q8, r3, r4, r5;
  logic signed [ROT_W-1:0] n4, n5, n6, n7, n8;
  logic [28:0] d4, d5;
  logic [32:0] nm5;
  logic        kbad5, kbad6;
  logic [57:0] dd6, nn6, u27, u28;
  logic [61:0] v26, v27, w8;

  // valid bits of the setup stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NSTG; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[1] <= s_axis_tvalid;
      for (int k = 2; k <= NSTG; k++) vld[k] <= vld[k-1];
    end
  end

  // setup stages: Q, R, N, D, U2 = D^2 - N^2, V2 = 4 L2^2 R
  always_ff @(posedge clk) begin
    if (en) begin
      pos[1] <= in_pos;
      for (int k = 2; k <= NSTG; k++) pos[k] <= pos[k-1];
      xx1   <= xsq[30:0];
      yy1   <= ysq[30:0];
      zz1   <= zsq[30:0];
      ll1   <= l1sq[26:0];
      l2sq1 <= l2sq;
      l3sq1 <= l3sq;
      l23_1 <= l23;
      eq1   <= (in_pos.y == POS_W'(in_pos.l1));
      // stage 2
      q2     <= $signed({2'b00, yy1}) + $signed({2'b00, zz1}) - $signed({6'b0, ll1});
      xx2    <= xx1;
      l2sq2  <= l2sq1;
      l3sq2  <= l3sq1;
      l23_2  <= l23_1;
      err[2] <= eq1;
      // stage 3: clamp negative Q
      q3     <= q2[32] ? '0 : q2[31:0];
      r3     <= {1'b0, xx2} + (q2[32] ? 32'd0 : q2[31:0]);
      l2sq3  <= l2sq2;
      l3sq3  <= l3sq2;
      l23_3  <= l23_2;
      err[3] <= err[2] | q2[32];
      // stage 4
      n4     <= $signed({2'b00, r3}) - $signed({6'b0, l2sq3}) - $signed({6'b0, l3sq3});
      d4     <= {l23_3, 1'b0};
      r4     <= r3;
      q4     <= q3;
      l2sq4  <= l2sq3;
      err[4] <= err[3] | (r3 == '0);
      // stage 5: knee ratio range check
      nm5    <= n4[ROT_W-1] ? 33'(-n4) : 33'(n4);
      kbad5  <= (d4 == '0) || ({4'b0, d4} < (n4[ROT_W-1] ? 33'(-n4) : 33'(n4)));
      n5     <= n4;
      d5     <= d4;
      r5     <= r4;
      q5     <= q4;
      l2sq5  <= l2sq4;
      err[5] <= err[4];
      // stage 6: products
      dd6    <= d5 * d5;
      nn6    <= nm5[28:0] * nm5[28:0];
      v26    <= {60'(l2sq5) * 60'(r5), 2'b00};
      kbad6  <= kbad5;
      n6     <= n5;
      q6     <= q5;
      err[6] <= err[5] | kbad5;
      // stage 7
      u27    <= kbad6 ? '0 : dd6 - nn6;
      v27    <= v26;
      n7     <= n6;
      q7     <= q6;
      err[7] <= err[6];
      // stage 8: calf term range check
      u28    <= u27;
      w8     <= ((v27 == '0) || ({4'b0, u27} > v27)) ? '0 : v27 - {4'b0, u27};
      n8     <= n7;
      q8     <= q7;
      err[8] <= err[7] | (v27 == '0) || ({4'b0, u27} > v27);
    end
  end

  // three square roots: sqrt(Q*2^16), sqrt(U2), sqrt(V2-U2)
  logic [2:0][RAD_W-1:0]  sq_rad;
  logic [2:0][ROOT_W-1:0] sq_root;
  sq_side_t sq_in, sq_out;
  logic sq_vld;

  assign sq_rad[0] = {14'b0, q8, 16'b0};
  assign sq_rad[1] = {4'b0, u28};
  assign sq_rad[2] = w8;
  assign sq_in.x   = pos[NSTG].x;
  assign sq_in.y   = pos[NSTG].y;
  assign sq_in.z   = pos[NSTG].z;
  assign sq_in.l1  = pos[NSTG].l1;
  assign sq_in.n   = n8;
  assign sq_in.err = err[NSTG];

  lik_sqrt #(
    .LANES  (3),
    .SIDE_W ($bits(sq_side_t))
  ) u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vld_i  (vld[NSTG]),
    .rad_i  (sq_rad),
    .side_i (sq_in),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_out)
  );

  // rotation operands
  logic signed [ROT_W-1:0] rq, sr, wr, za, bt, aa, xa, nabs;
  logic [3:0][ROT_W-1:0] op_x, op_y, rx9, ry9;
  rot_side_t rs9, rot_side;
  logic vld9, rot_vld;

  always_comb begin
    rq   = ROT_W'(sq_root[0]);
    sr   = ROT_W'(sq_root[1]);
    wr   = ROT_W'(sq_root[2]);
    za   = ROT_W'(sq_out.z) <<< 8;
    bt   = (ROT_W'(sq_out.y) - ROT_W'(sq_out.l1)) <<< 8;
    aa   = za + rq;
    xa   = ROT_W'(sq_out.x) <<< 8;
    nabs = sq_out.n[ROT_W-1] ? -sq_out.n : sq_out.n;
    // abduction: keep the x operand non-negative
    if (bt < 0) begin
      op_y[0] = -aa;
      op_x[0] = -bt;
    end else begin
      op_y[0] = aa;
      op_x[0] = bt;
    end
    op_y[1] = sr;
    op_x[1] = nabs;
    op_y[2] = xa;
    op_x[2] = rq;
    op_y[3] = sr;
    op_x[3] = wr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld9 <= 1'b0;
    end else if (en) begin
      vld9 <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx9      <= op_x;
      ry9      <= op_y;
      rs9.err  <= sq_out.err;
      rs9.nneg <= sq_out.n[ROT_W-1];
    end
  end

  logic [3:0][ACC_W-1:0] ang;

  lik_rot #(
    .LANES  (4),
    .SIDE_W ($bits(rot_side_t)),
    .ITER   (ANGLE_ITERATIONS)
  ) u_rot (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vld_i  (vld9),
    .x_i    (rx9),
    .y_i    (ry9),
    .side_i (rs9),
    .vld_o  (rot_vld),
    .ang_o  (ang),
    .side_o (rot_side)
  );

  // combine angles and round to Q3.13
  logic signed [34:0] abd, knee, pitch;

  always_comb begin
    abd   = 35'($signed(ang[0])) <<< 1;
    knee  = rot_side.nneg ? 35'($signed(ang[1])) - 35'(PI_Q29)
                          : -35'($signed(ang[1]));
    pitch = 35'($signed(ang[3])) - 35'($signed(ang[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= rot_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {to_q13(knee), to_q13(pitch), to_q13(abd)};
      m_axis_tuser <= rot_side.err;
    end
  end

  assign m_axis_tvalid = out_vld;

endmodule

FILE: rtl/core/lik_chk.sv
// Port-level checks for the leg inverse kinematics top, bound to it.
module lik_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output word valid right after reset");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a stall holds the input back as well
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken during output stall");

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result word changed while stalled");

endmodule

bind leg_inverse_kinematics_3dof lik_chk u_lik_chk (.*);

FILE: test/lik_checker.sv
// Checker for the leg inverse kinematics block: predicts angles and compares output words.
module lik_checker
  import lik_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [47:0]          m_axis_tdata,
  input  logic [0:0]           m_axis_tuser,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_addr,
  input  logic [LEN_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITERS = ANGLE_ITERATIONS_DEF;
  localparam longint PI29 = 64'd1686629713;

  typedef struct {
    logic [15:0] abd;
    logic [15:0] pitch;
    logic [15:0] knee;
    logic        err;
  } joint_angles_t;

  joint_angles_t angle_q[$];
  logic [LEN_W-1:0] thigh, calf;

  function automatic longint fshr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned absval(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // vectoring rotation, x >= 0, angle in Q2.29
  function automatic longint vec_angle(longint y, longint x);
    longint unsigned m;
    longint ang, dx, dy;
    m = absval(x) > absval(y) ? absval(x) : absval(y);
    ang = 0;
    if (m == 0) return 0;
    while (m >= (64'd1 << 30)) begin
      x = fshr(x, 1);
      y = fshr(y, 1);
      m >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      x *= 2;
      y *= 2;
      m <<= 1;
    end
    for (int i = 0; i < ITERS; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; ang += rot_atan(i);
      end else begin
        x -= dx; y += dy; ang -= rot_atan(i);
      end
    end
    return ang;
  endfunction

  function automatic logic [15:0] round_q13(longint a);
    longint t;
    t = fshr(a + 32768, 16);
    return t[15:0];
  endfunction

  function automatic joint_angles_t solve_leg(logic [63:0] w);
    joint_angles_t res;
    longint x, y, z, l1, l2, l3, q, r, a, b, abd, n, kn, t1, t2;
    longint unsigned d, nm, u2, v2, s, wr, rq;
    x = longint'($signed(w[15:0]));
    y = longint'($signed(w[31:16]));
    z = longint'($signed(w[47:32]));
    l1 = longint'($signed(w[61:48]));
    l2 = longint'(thigh);
    l3 = longint'(calf);
    res.err = 1'b0;
    u2 = 0;
    q = y * y + z * z - l1 * l1;
    if (q < 0) begin res.err = 1'b1; q = 0; end
    r = x * x + q;
    if (r == 0) res.err = 1'b1;
    rq = int_sqrt(longint'(q) << 16);
    // abduction
    a = z * 256 + longint'(rq);
    b = (y - l1) * 256;
    if (b == 0) res.err = 1'b1;
    if (b < 0) begin a = -a; b = -b; end
    abd = 2 * vec_angle(a, b);
    // knee
    n = r - l2 * l2 - l3 * l3;
    d = 2 * l2 * l3;
    nm = absval(n);
    if (d == 0 || nm > d) res.err = 1'b1;
    else u2 = d * d - nm * nm;
    s = int_sqrt(u2);
    if (n >= 0) kn = -vec_angle(longint'(s), n);
    else kn = -(PI29 - vec_angle(longint'(s), -n));
    // hip pitch
    t1 = vec_angle(x * 256, longint'(rq));
    v2 = 4 * l2 * l2 * longint'(r);
    if (v2 == 0 || u2 > v2) begin
      res.err = 1'b1;
      wr = 0;
    end else begin
      wr = int_sqrt(v2 - u2);
    end
    t2 = vec_angle(longint'(s), longint'(wr));
    res.abd = round_q13(abd);
    res.pitch = round_q13(t2 - t1);
    res.knee = round_q13(kn);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  assign pending = angle_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    joint_angles_t e;
    if (rst) begin
      thigh <= THIGH_RST;
      calf <= CALF_RST;
    end else begin
      if (cfg_we) begin
        if (cfg_reg_t'(cfg_addr) == REG_THIGH) thigh <= cfg_wdata;
        else calf <= cfg_wdata;
      end
      if (s_axis_tvalid && s_axis_tready) angle_q.push_back(solve_leg(s_axis_tdata));
      // compare output word with oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (angle_q.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata[15:0], 16'h0);
        end else begin
          e = angle_q.pop_front();
          if (m_axis_tdata[15:0] !== e.abd) report_mismatch("abduction", m_axis_tdata[15:0], e.abd);
          if (m_axis_tdata[31:16] !== e.pitch)
            report_mismatch("hip_pitch", m_axis_tdata[31:16], e.pitch);
          if (m_axis_tdata[47:32] !== e.knee)
            report_mismatch("knee", m_axis_tdata[47:32], e.knee);
          if (m_axis_tuser[0] !== e.err)
            report_mismatch("reach_error", {15'd0, m_axis_tuser[0]}, {15'd0, e.err});
        end
      end
    end
  end
endmodule

FILE: test/tb_leg_inverse_kinematics_3dof.sv
// Testbench top: stimulus, configuration phases and verdict for the leg IK block.
module tb_leg_inverse_kinematics_3dof;
  timeunit 1ns;
  timeprecision 1ps;
  import lik_pkg::*;

  localparam int LATENCY = 49 + ANGLE_ITERATIONS_DEF;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_addr = '0;
  logic [LEN_W-1:0] cfg_wdata = '0;
  int fail_count, pending;
  longint cycles = 0;
  bit sink_hold = 1'b0;
  bit sink_hold_done = 1'b0;

  always #10 clk = ~clk;

  leg_inverse_kinematics_3dof u_top (.*);

  lik_checker u_checker (.*);

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stall, plus one long hold-off
  initial begin
    int g;
    @(posedge clk iff !rst);
    forever begin
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
        repeat (3 * LATENCY) @(posedge clk);
        sink_hold_done = 1'b1;
        sink_hold = 1'b0;
      end
      g = gap_len();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_leg_inverse_kinematics_3dof NOT OK");
      $finish;
    end
  end

  // valid stays high after the word is taken; the next call or an idle step drops it
  task automatic send_target(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [13:0] l1);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, l1, z, y, x};
    @(posedge clk iff s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_len(cfg_reg_t idx, logic [LEN_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // leg-like target for current lengths: random x and z within a random reach up to l2 + l3, y near l1
  task automatic send_leg_like(int l2, int l3);
    int l1, reach, x, y, z;
    l1 = $urandom_range(0, 1600) - 800;
    reach = $urandom_range(1, l2 + l3);
    x = $urandom_range(0, 2 * reach) - reach;
    z = -$urandom_range(0, reach);
    y = l1 + $urandom_range(0, 400) - 200;
    send_target(x[15:0], y[15:0], z[15:0], l1[13:0]);
  endtask

  task automatic send_noise();
    send_target(16'($urandom), 16'($urandom), 16'($urandom), 14'($urandom));
  endtask

  initial begin
    int l2, l3, phase_cnt;
    int phase_thigh[5] = '{3200, 1, 16383, 2000, 4500};
    int phase_calf[5]  = '{3200, 16383, 1, 2500, 1};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes and each special case
    send_target(16'h0000, 16'h0000, 16'h0000, 14'h0000);   // zero everything
    send_target(16'h7fff, 16'h7fff, 16'h7fff, 14'h1fff);
    send_target(16'h8000, 16'h8000, 16'h8000, 14'h2000);
    send_target(16'h7fff, 16'h8000, 16'h7fff, 14'h2000);
    send_target(16'h0000, 16'd100, 16'd0, 14'd1000);        // negative Q
    send_target(16'd0, 16'd300, 16'd400, 14'd500);           // zero R
    send_target(16'd50, 16'd200, 16'hff00, 14'd200);         // y equals offset
    send_target(16'd50, 16'd200, 16'd0, 14'd200);            // y - offset zero, z zero
    send_target(16'd0, 16'd0, -16'sd6400, 14'd0);            // full stretch
    send_target(16'd0, 16'd0, -16'sd3000, 14'd0);
    send_target(16'd10, 16'd5, -16'sd1, 14'd0);              // too close, knee -pi
    send_target(16'd20000, 16'd0, 16'd0, 14'd0);             // beyond reach
    send_target(16'hf000, 16'd700, -16'sd4000, 14'd600);
    send_target(16'd1000, 16'hfd00, -16'sd4000, 14'h3d00);
    drain();

    // random phases over several length settings; one long receiver hold-off
    for (int p = 0; p < 5; p++) begin
      l2 = phase_thigh[p];
      l3 = phase_calf[p];
      write_len(REG_THIGH, l2[13:0]);
      write_len(REG_CALF, l3[13:0]);
      phase_cnt = 250;
      for (int i = 0; i < phase_cnt; i++) begin
        if (p == 1 && i == 20) sink_hold = 1'b1;
        if (p == 2 && i == 100) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        if ($urandom_range(0, 9) < 8) send_leg_like(l2, l3);
        else send_noise();
      end
      drain();
    end

    if (fail_count == 0 && sink_hold_done) begin
      $display("tb_leg_inverse_kinematics_3dof OK");
    end else begin
      $display("tb_leg_inverse_kinematics_3dof NOT OK");
    end
    $finish;
  end
endmodule
